FILE: sv/bldq_pkg.sv
// Shared codes and field widths for the bounded linked deque.
`timescale 1ns / 1ps

package bldq_pkg;

  // Field widths of one request and one answer
  localparam int VALUE_W     = 32;
  localparam int POS_W       = 6;
  localparam int KIND_W      = 2;
  localparam int STATUS_W    = 2;
  localparam int COUNT_W     = 7;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 48;

  // Request kinds
  localparam logic [KIND_W-1:0] KIND_INS_FRONT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_INS_BACK  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_REMOVE    = 2'd2;

  // Answer status codes
  localparam logic [STATUS_W-1:0] STATUS_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

endpackage

FILE: sv/bounded_linked_deque_with_indexed_remove_top.sv
// Bounded doubly linked deque with removal by position, kept in link memories.
//
// Usage: one request enters on the s_ channel (tuser carries the kind, tdata the
// value and the position) and exactly one answer leaves on the m_ channel with
// the removed value, a status and the entry count after the request.
// Requests are handled one at a time. An insert writes the new node, then links
// its neighbour before the answer register is loaded (no link step into an
// empty list); a remove at position p walks p links along the forward-link
// memory, one read per cycle from the head, then takes, unlinks and frees the
// node. A refused request (store full, position past the end, unused kind)
// goes straight to the answer. The next request is taken in the cycle after the
// answer is loaded.
// The answer sits in an output register; a new request is taken while it waits.
// If the receiver stalls, the next answer is held back until the register is
// free, and no further request is taken until then.
// Reset (synchronous, rst high) empties the list and frees every slot at once:
// slots never used are handed out in order from a fill count, so no clearing
// pass is needed and the block is ready in the first cycle after reset.
`timescale 1ns / 1ps

module bounded_linked_deque_with_indexed_remove_top
  import bldq_pkg::*;
#(
  parameter int CAPACITY = 64
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // [31:0] item_value, [37:32] position, [39:38] zero
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  // [1:0] kind
  input  logic [KIND_W-1:0]      s_tuser,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // [31:0] removed_value, [33:32] status, [40:34] entry_count, [47:41] zero
  output logic [OUT_TDATA_W-1:0] m_tdata
);

  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int LW = $clog2(CAPACITY + 1);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [LW-1:0] NIL = LW'(CAPACITY);
  localparam logic [CW-1:0] FULL_COUNT = CW'(CAPACITY);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_INS    = 3'd1;
  localparam logic [2:0] ST_LINK   = 3'd2;
  localparam logic [2:0] ST_WALK   = 3'd3;
  localparam logic [2:0] ST_TAKE   = 3'd4;
  localparam logic [2:0] ST_UNLINK = 3'd5;
  localparam logic [2:0] ST_FREE   = 3'd6;
  localparam logic [2:0] ST_DONE   = 3'd7;

  // Node store
  logic [VALUE_W-1:0] val_mem [CAPACITY];
  logic [LW-1:0]      fwd_mem [CAPACITY];
  logic [LW-1:0]      bwd_mem [CAPACITY];

  logic [VALUE_W-1:0] val_rd;
  logic [LW-1:0]      fwd_rd;
  logic [LW-1:0]      bwd_rd;

  logic               val_we, fwd_we, bwd_we;
  logic [IW-1:0]      val_wa, fwd_wa, bwd_wa;
  logic [VALUE_W-1:0] val_wd;
  logic [LW-1:0]      fwd_wd, bwd_wd;
  logic [IW-1:0]      fwd_ra, node_ra;

  // Control and list registers
  logic [2:0]          state;
  logic [KIND_W-1:0]   kind_r;
  logic [VALUE_W-1:0]  value_r;
  logic [POS_W-1:0]    left;
  logic                step;
  logic [LW-1:0]       cur;
  logic [LW-1:0]       slot;
  logic [LW-1:0]       nbr;
  logic [LW-1:0]       first;
  logic [LW-1:0]       last;
  logic [LW-1:0]       free_head;
  logic [LW-1:0]       fresh;
  logic [CW-1:0]       count;
  logic [VALUE_W-1:0]  res_removed;
  logic [STATUS_W-1:0] res_status;

  logic [LW-1:0]       node_eff;
  logic                list_empty;
  logic                at_front;
  logic [CW+POS_W-1:0] pos_w;
  logic [CW+POS_W-1:0] cnt_w;
  logic [CW+COUNT_W-1:0] cnt_out;
  logic                out_free;

  logic [VALUE_W-1:0]  in_value;
  logic [POS_W-1:0]    in_pos;

  assign in_value = s_tdata[VALUE_W-1:0];
  assign in_pos   = s_tdata[VALUE_W+POS_W-1:VALUE_W];

  assign s_tready   = (state == ST_IDLE);
  assign node_eff   = step ? fwd_rd : cur;
  assign list_empty = (first == NIL);
  assign at_front   = (kind_r == KIND_INS_FRONT);
  assign pos_w      = (CW + POS_W)'(in_pos);
  assign cnt_w      = (CW + POS_W)'(count);
  assign cnt_out    = (CW + COUNT_W)'(count);
  assign out_free   = !m_tvalid || m_tready;

  // Forward-link read address: the free head while idle, the walking node otherwise
  assign node_ra = node_eff[IW-1:0];
  assign fwd_ra  = (state == ST_IDLE) ? free_head[IW-1:0] : node_ra;

  // Memory write steering per step
  always_comb begin
    val_we = 1'b0;
    val_wa = slot[IW-1:0];
    val_wd = value_r;
    fwd_we = 1'b0;
    fwd_wa = slot[IW-1:0];
    fwd_wd = NIL;
    bwd_we = 1'b0;
    bwd_wa = slot[IW-1:0];
    bwd_wd = NIL;
    case (state)
      ST_INS: begin
        val_we = 1'b1;
        fwd_we = 1'b1;
        bwd_we = 1'b1;
        fwd_wd = (!list_empty && at_front) ? first : NIL;
        bwd_wd = (!list_empty && !at_front) ? last : NIL;
      end
      ST_LINK: begin
        if (at_front) begin
          bwd_we = 1'b1;
          bwd_wa = nbr[IW-1:0];
          bwd_wd = slot;
        end else begin
          fwd_we = 1'b1;
          fwd_wa = nbr[IW-1:0];
          fwd_wd = slot;
        end
      end
      ST_UNLINK: begin
        fwd_we = (bwd_rd != NIL);
        fwd_wa = bwd_rd[IW-1:0];
        fwd_wd = fwd_rd;
        bwd_we = (fwd_rd != NIL);
        bwd_wa = fwd_rd[IW-1:0];
        bwd_wd = bwd_rd;
      end
      ST_FREE: begin
        fwd_we = 1'b1;
        fwd_wa = cur[IW-1:0];
        fwd_wd = free_head;
      end
      default: begin
        val_we = 1'b0;
      end
    endcase
  end

  // Value memory
  always_ff @(posedge clk) begin
    if (val_we) begin
      val_mem[val_wa] <= val_wd;
    end
    val_rd <= val_mem[node_ra];
  end

  // Forward-link memory
  always_ff @(posedge clk) begin
    if (fwd_we) begin
      fwd_mem[fwd_wa] <= fwd_wd;
    end
    fwd_rd <= fwd_mem[fwd_ra];
  end

  // Backward-link memory
  always_ff @(posedge clk) begin
    if (bwd_we) begin
      bwd_mem[bwd_wa] <= bwd_wd;
    end
    bwd_rd <= bwd_mem[node_ra];
  end

  // Sequencer and list registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      first     <= NIL;
      last      <= NIL;
      free_head <= '0;
      fresh     <= '0;
      count     <= '0;
      m_tvalid  <= 1'b0;
    end else begin
      // Drop the answer once taken, unless a new one is loaded now
      if (m_tvalid && m_tready && state != ST_DONE) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            kind_r      <= s_tuser;
            value_r     <= in_value;
            res_removed <= '0;
            cur         <= first;
            step        <= 1'b0;
            left        <= in_pos;
            slot        <= free_head;
            case (s_tuser)
              KIND_INS_FRONT, KIND_INS_BACK: begin
                if (count == FULL_COUNT) begin
                  res_status <= STATUS_FULL;
                  state      <= ST_DONE;
                end else begin
                  res_status <= STATUS_DONE;
                  state      <= ST_INS;
                end
              end
              KIND_REMOVE: begin
                if (pos_w >= cnt_w) begin
                  res_status <= STATUS_RANGE;
                  state      <= ST_DONE;
                end else if (in_pos == '0) begin
                  res_status <= STATUS_DONE;
                  state      <= ST_TAKE;
                end else begin
                  res_status <= STATUS_DONE;
                  state      <= ST_WALK;
                end
              end
              default: begin
                res_status <= STATUS_DONE;
                state      <= ST_DONE;
              end
            endcase
          end
        end
        ST_INS: begin
          // Pop the free list: untouched slots come in order from the fill count
          if (free_head == fresh) begin
            free_head <= free_head + LW'(1);
            fresh     <= fresh + LW'(1);
          end else begin
            free_head <= fwd_rd;
          end
          count <= count + CW'(1);
          if (list_empty) begin
            first <= slot;
            last  <= slot;
            state <= ST_DONE;
          end else if (at_front) begin
            nbr   <= first;
            first <= slot;
            state <= ST_LINK;
          end else begin
            nbr   <= last;
            last  <= slot;
            state <= ST_LINK;
          end
        end
        ST_LINK: begin
          state <= ST_DONE;
        end
        ST_WALK: begin
          // Advance one node per cycle through the forward links
          step <= 1'b1;
          left <= left - POS_W'(1);
          if (left == POS_W'(1)) begin
            state <= ST_TAKE;
          end
        end
        ST_TAKE: begin
          cur   <= node_eff;
          state <= ST_UNLINK;
        end
        ST_UNLINK: begin
          res_removed <= val_rd;
          if (bwd_rd == NIL) begin
            first <= fwd_rd;
          end
          if (fwd_rd == NIL) begin
            last <= bwd_rd;
          end
          count <= count - CW'(1);
          state <= ST_FREE;
        end
        ST_FREE: begin
          free_head <= cur;
          state     <= ST_DONE;
        end
        ST_DONE: begin
          // Hold the answer until the output register is free
          if (out_free) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {(OUT_TDATA_W - VALUE_W - STATUS_W - COUNT_W)'(0),
                         cnt_out[COUNT_W-1:0], res_status, res_removed};
            state    <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: sv/bldq_checker.sv
// Port-level checks for the bounded linked deque, bound to its top level.
`timescale 1ns / 1ps

module bldq_checker
  import bldq_pkg::*;
#(
  parameter int CAPACITY = 64
) (
  input logic                   clk,
  input logic                   rst,
  input logic                   s_tvalid,
  input logic                   s_tready,
  input logic [IN_TDATA_W-1:0]  s_tdata,
  input logic [KIND_W-1:0]      s_tuser,
  input logic                   m_tvalid,
  input logic                   m_tready,
  input logic [OUT_TDATA_W-1:0] m_tdata
);

  logic [STATUS_W-1:0] out_status;
  logic [COUNT_W-1:0]  out_count;

  assign out_status = m_tdata[VALUE_W+STATUS_W-1:VALUE_W];
  assign out_count  = m_tdata[VALUE_W+STATUS_W+COUNT_W-1:VALUE_W+STATUS_W];

  // Hold a stalled answer
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("answer changed while stalled");

  // Take one request at a time
  assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("second request taken while one is in work");

  // Report only defined status codes
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (out_status == STATUS_DONE || out_status == STATUS_RANGE ||
                  out_status == STATUS_FULL))
    else $error("undefined status code");

  // Return zero for a refused request
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && out_status != STATUS_DONE |-> m_tdata[VALUE_W-1:0] == '0)
    else $error("refused request returned a value");

  // Never count past the store
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && CAPACITY < (1 << COUNT_W) |-> int'(out_count) <= CAPACITY)
    else $error("entry count beyond capacity");

endmodule

bind bounded_linked_deque_with_indexed_remove_top bldq_checker #(
  .CAPACITY(CAPACITY)
) u_bldq_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
